FILE: rtl/core/gwm_pkg.sv
// Shared types, character codes and helpers for the glob wildcard matcher.
// No dependencies; used by every module under rtl/core.

package gwm_pkg;

	// Default size of the token store.
	localparam int PATTERN_MAX_DEF = 64;

	// Depth of the command queue between the parser and the NFA engine.
	localparam int QUEUE_DEPTH = 4;

	// Request kinds carried on the input tuser.
	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_DATA    = 1'b1;

	// Characters with a meaning in the pattern grammar.
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_ONE  = 8'h3F;
	localparam logic [7:0] CHAR_ESC  = 8'h5C;

	typedef enum logic [1:0] {
		KIND_LIT  = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_STAR = 2'd2
	} tok_kind_t;

	// One parsed command. Several flags may be set together: restart comes
	// first, then add, close, step and term, in that order.
	typedef struct packed {
		logic       restart; // new pattern: drop tokens and overflow
		logic       add;     // append one token
		logic       close;   // pattern done: NFA back to its start set
		logic       step;    // advance the NFA over one data byte
		logic       term;    // end of data string: report a result
		tok_kind_t  kind;
		logic [7:0] ch;
	} cmd_t;

	// ASCII A-Z folded onto a-z.
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/gwm_front.sv
// Front end: accepts input items, tracks pattern escape/closed state and
// turns each item into one command. Depends on gwm_pkg.

module gwm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	input  logic [7:0]    byte_value,
	input  logic          q_space,
	output logic          push,
	output gwm_pkg::cmd_t cmd
);

	logic escape_q;
	logic closed_q;
	logic escape_nx;
	logic closed_nx;
	logic esc_eff;

	assign in_ready = q_space;
	assign push     = in_valid && q_space;

	always_comb begin
		cmd       = '0;
		cmd.kind  = gwm_pkg::KIND_LIT;
		cmd.ch    = byte_value;
		escape_nx = escape_q;
		closed_nx = closed_q;
		esc_eff   = closed_q ? 1'b0 : escape_q;
		if (req_type == gwm_pkg::REQ_PATTERN) begin
			cmd.restart = closed_q;
			if (byte_value == gwm_pkg::CHAR_NUL) begin
				cmd.close = 1'b1;
				closed_nx = 1'b1;
				escape_nx = 1'b0;
			end else begin
				closed_nx = 1'b0;
				escape_nx = 1'b0;
				if (esc_eff) begin
					cmd.add = 1'b1;
				end else begin
					case (byte_value)
						gwm_pkg::CHAR_ESC: begin
							escape_nx = 1'b1;
						end
						gwm_pkg::CHAR_STAR: begin
							cmd.add  = 1'b1;
							cmd.kind = gwm_pkg::KIND_STAR;
						end
						gwm_pkg::CHAR_ONE: begin
							cmd.add  = 1'b1;
							cmd.kind = gwm_pkg::KIND_ONE;
						end
						default: begin
							cmd.add = 1'b1;
						end
					endcase
				end
			end
		end else begin
			// data closes an open pattern first; a pending escape is dropped
			cmd.close = !closed_q;
			closed_nx = 1'b1;
			escape_nx = 1'b0;
			if (byte_value == gwm_pkg::CHAR_NUL) begin
				cmd.term = 1'b1;
			end else begin
				cmd.step = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			closed_q <= 1'b1;
		end else if (push) begin
			escape_q <= escape_nx;
			closed_q <= closed_nx;
		end
	end

endmodule

FILE: rtl/core/gwm_cmd_fifo.sv
// Short command queue between the parser and the NFA engine.
// Depends on gwm_pkg for the command type.

module gwm_cmd_fifo #(
	parameter int DEPTH = gwm_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gwm_pkg::cmd_t push_cmd,
	output logic          space,
	output logic          head_valid,
	output gwm_pkg::cmd_t head,
	input  logic          pop
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	gwm_pkg::cmd_t     slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign space      = fill_q < FILL_W'(DEPTH);
	assign head_valid = fill_q != '0;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/gwm_back.sv
// Back end: token cells, bit-parallel NFA over pattern positions and the
// result register. Depends on gwm_pkg.

module gwm_back #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  gwm_pkg::cmd_t head,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output logic          res_matched,
	output logic          res_overflow
);

	localparam int CNT_W = $clog2(PATTERN_MAX + 1);
	localparam int POS   = PATTERN_MAX + 1;

	gwm_pkg::tok_kind_t tok_kind_q [PATTERN_MAX];
	logic [7:0]         tok_ch_q   [PATTERN_MAX];

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [POS-1:0]   start_q;   // closure of position 0, kept as tokens arrive
	logic [POS-1:0]   active_q;
	logic             out_valid_q;
	logic             out_matched_q;
	logic             out_ovf_q;

	logic [CNT_W-1:0]   cnt_b;
	logic [CNT_W-1:0]   cnt_inc;
	logic               ovf_b;
	logic [POS-1:0]     start_b;
	logic [POS-1:0]     base;
	logic               room;
	logic               do_add;
	logic [7:0]         ch_fold;
	logic [PATTERN_MAX-1:0] star_v;
	logic [PATTERN_MAX-1:0] stay;
	logic [PATTERN_MAX-1:0] adv;
	logic [POS-1:0]     raw;
	logic [POS-1:0]     spine;
	logic [POS-1:0]     seeds;
	logic [POS-1:0]     closed;
	logic [CNT_W-1:0]   count_nx;
	logic               ovf_nx;
	logic [POS-1:0]     start_nx;

	assign pop     = head_valid && (!head.term || !out_valid_q || res_ready);
	assign cnt_b   = head.restart ? '0 : count_q;
	assign ovf_b   = head.restart ? 1'b0 : ovf_q;
	assign start_b = head.restart ? POS'(1) : start_q;
	assign room    = cnt_b < CNT_W'(PATTERN_MAX);
	assign cnt_inc = cnt_b + CNT_W'(1);
	assign do_add  = pop && head.add && room;
	assign base    = head.close ? start_b : active_q;
	assign ch_fold = gwm_pkg::fold(head.ch);

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic live;
		logic hit;
		assign live = CNT_W'(i) < count_q;
		assign star_v[i] = live && (tok_kind_q[i] == gwm_pkg::KIND_STAR);
		assign hit = live && ((tok_kind_q[i] == gwm_pkg::KIND_ONE) ||
			((tok_kind_q[i] == gwm_pkg::KIND_LIT) && (tok_ch_q[i] == ch_fold)));
		assign stay[i] = base[i] && star_v[i];
		assign adv[i]  = base[i] && hit;

		// literals are kept folded
		always_ff @(posedge clk) begin
			if (do_add && (cnt_b == CNT_W'(i))) begin
				tok_kind_q[i] <= head.kind;
				tok_ch_q[i]   <= gwm_pkg::fold(head.ch);
			end
		end
	end

	// Star closure as a carry chain: a seed on a run of stars carries
	// through the run and lands one past its end.
	assign raw    = {1'b0, stay} | {adv, 1'b0};
	assign spine  = {1'b0, star_v};
	assign seeds  = raw & spine;
	assign closed = raw | ((spine + seeds) ^ spine);

	always_comb begin
		count_nx = cnt_b;
		ovf_nx   = ovf_b;
		start_nx = start_b;
		if (head.add) begin
			if (room) begin
				count_nx = cnt_inc;
				start_nx[cnt_inc] = start_b[cnt_b] && (head.kind == gwm_pkg::KIND_STAR);
			end else begin
				ovf_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			start_q     <= POS'(1);
			active_q    <= POS'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
				start_q <= start_nx;
				if (head.step) begin
					active_q <= closed;
				end else if (head.close || head.term) begin
					active_q <= start_b;
				end
			end
			if (pop && head.term) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.term) begin
			out_matched_q <= !ovf_b && base[cnt_b];
			out_ovf_q     <= ovf_b;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_matched  = out_matched_q;
	assign res_overflow = out_ovf_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PATTERN_MAX))
		else $error("token count beyond store");

	a_start_pos0: assert property (@(posedge clk) disable iff (!arst_n)
		start_q[0])
		else $error("start set lost position zero");

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_matched_q && out_ovf_q))
		else $error("match reported on overflowed pattern");

	a_term_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.term) |=> (active_q == start_q))
		else $error("NFA not back at start set after a result");

endmodule

FILE: rtl/core/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: parser, command queue, NFA engine.
// Depends on gwm_pkg, gwm_front, gwm_cmd_fifo and gwm_back.
// Usage:
//  - Input stream s_axis: tuser selects pattern byte (0) or data byte (1),
//    tdata carries the byte. A pattern is a run of pattern bytes ending in
//    zero; '?' matches any one byte, '*' any run, backslash quotes the next
//    byte. Data strings are runs of data bytes ending in zero.
//  - Output stream m_axis: one item per data terminator, tdata[0] = matched,
//    tdata[1] = pattern overflow (pattern longer than PATTERN_MAX tokens).
//  - Throughput: one input item per cycle while s_axis_tready is high. The NFA
//    engine advances every pattern position together, one 8-bit compare per
//    token cell plus a PATTERN_MAX+1 bit carry chain for the star closure.
//  - Result path: a terminator passes through the command queue and then
//    the result register before m_axis_tvalid rises.
//  - Stall: the result register holds while m_axis_tready is low; the
//    engine keeps taking commands that produce no result, and the
//    QUEUE_DEPTH-entry queue (four by default) absorbs input until it is
//    full, then s_axis_tready drops.
//  - Reset (arst_n low): empty pattern (matches only the empty string),
//    queue empty, no result pending. No clearing pass is needed.

module glob_wildcard_matcher #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
	parameter int QUEUE_DEPTH = gwm_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
	input  logic       s_axis_tuser,   // [0] req_type
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow
);

	logic          q_space;
	logic          push;
	gwm_pkg::cmd_t push_cmd;
	logic          head_valid;
	gwm_pkg::cmd_t head;
	logic          pop;
	logic          res_matched;
	logic          res_overflow;

	gwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.req_type   (s_axis_tuser),
		.byte_value (s_axis_tdata),
		.q_space    (q_space),
		.push       (push),
		.cmd        (push_cmd)
	);

	gwm_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.space      (q_space),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	gwm_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_matched  (res_matched),
		.res_overflow (res_overflow)
	);

	assign m_axis_tdata = {6'b0, res_overflow, res_matched};

endmodule
